[rtl/swpt_pkg.sv]
// Shared constants and types of the sliding window percentile tracker.
package swpt_pkg;

   // ring size and derived widths
   localparam int WINDOW = 50;
   localparam int IDX_W  = $clog2(WINDOW);
   localparam int CNT_W  = $clog2(WINDOW + 1);
   localparam int KW     = CNT_W + 1;

   // field widths
   localparam int DUR_W   = 32;
   localparam int SAMP_W  = 16;
   localparam int LIMIT_W = 24;
   localparam int PCT_W   = 7;
   localparam int MS_W    = 7;
   localparam int BIT_W   = $clog2(SAMP_W);

   // csr port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 24;
   localparam logic [CSR_IDX_W-1:0] REG_REJECT_LIMIT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_PERCENTILE   = 2'd1;
   localparam logic [LIMIT_W-1:0]   LIMIT_RESET      = 24'd6000000;
   localparam logic [PCT_W-1:0]     PCT_RESET        = 7'd95;

   localparam logic [SAMP_W-1:0] SAMP_MAX = 16'hFFFF;

   // rank = floor(n * pct / 100), by reciprocal multiply
   localparam int PROD_W       = CNT_W + PCT_W;
   localparam int DIV100_MUL_W = 13;
   localparam logic [DIV100_MUL_W-1:0] DIV100_MUL = 13'd5243;
   localparam int DIV100_SHIFT = 19;
   localparam int DIVP_W       = PROD_W + DIV100_MUL_W;

   // ms = floor((u + 500) / 1000), by reciprocal multiply
   localparam logic [SAMP_W:0] ROUND_HALF = 17'd500;
   localparam int DIV1000_MUL_W = 17;
   localparam logic [DIV1000_MUL_W-1:0] DIV1000_MUL = 17'd67109;
   localparam int DIV1000_SHIFT = 26;
   localparam int CONV_W        = SAMP_W + 1 + DIV1000_MUL_W;
   localparam int MS_MAX        = 66;

   // population count tree
   localparam int GRP_SIZE  = 8;
   localparam int NGRP      = (WINDOW + GRP_SIZE - 1) / GRP_SIZE;
   localparam int GRP_CNT_W = $clog2(GRP_SIZE + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RANK_MUL,
      ST_RANK_DIV,
      ST_COUNT,
      ST_DECIDE,
      ST_CONV_MUL,
      ST_RESULT
   } swpt_state_type;

endpackage

[rtl/sliding_window_percentile_tracker.sv]
// Top level: sample ring with bit-serial radix selection of the percentile.
//
//  channel | direction | handshake              | payload
//  req     | in        | req_valid / req_stall  | req_duration_us
//  rsp     | out       | rsp_valid / rsp_stall  | rsp_accepted, rsp_percentile_ms, rsp_worst_us
//  csr     | in        | csr_valid / csr_ready  | csr_index, csr_data
//
// One sample at a time: after accept it steps through rank multiply, rank divide,
// count and decide for each of the 16 sample bits MSB first (group popcount, then
// decide), conversion multiply and result, which raises rsp_valid; req_stall holds
// off new samples until it is back in idle, also while the result waits on rsp_stall.
// Reset clears config, counters and worst value; ring entries past the held
// count are never read, so the ring itself needs no clearing.
module sliding_window_percentile_tracker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [swpt_pkg::DUR_W-1:0]         req_duration_us,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_accepted,
   output logic [swpt_pkg::MS_W-1:0]          rsp_percentile_ms,
   output logic [swpt_pkg::LIMIT_W-1:0]       rsp_worst_us,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [swpt_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [swpt_pkg::CSR_DATA_W-1:0]    csr_data
);
   import swpt_pkg::*;

   swpt_state_type         state_ff, state_in;
   logic [LIMIT_W-1:0]     limit_ff, limit_in;
   logic [PCT_W-1:0]       pct_ff, pct_in;
   logic [IDX_W-1:0]       wr_idx_ff, wr_idx_in;
   logic [CNT_W-1:0]       held_ff, held_in;
   logic [LIMIT_W-1:0]     worst_ff, worst_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   logic [SAMP_W-1:0]      ring_ff [WINDOW];
   logic [SAMP_W-1:0]      ring_in [WINDOW];
   logic                   acc_ff, acc_in;
   logic [PROD_W-1:0]      rank_prod_ff, rank_prod_in;
   logic [KW-1:0]          k_rem_ff, k_rem_in;
   logic [WINDOW-1:0]      alive_ff, alive_in;
   logic [GRP_CNT_W-1:0]   grp_cnt_ff [NGRP];
   logic [GRP_CNT_W-1:0]   grp_cnt_in [NGRP];
   logic [BIT_W-1:0]       bit_ff, bit_in;
   logic [SAMP_W-1:0]      sel_ff, sel_in;
   logic [CONV_W-1:0]      conv_ff, conv_in;
   logic                   rsp_acc_ff, rsp_acc_in;
   logic [MS_W-1:0]        rsp_ms_ff, rsp_ms_in;
   logic [LIMIT_W-1:0]     rsp_worst_ff, rsp_worst_in;

   logic [WINDOW-1:0]      zero_bits;
   logic [DIVP_W-1:0]      div_prod;
   logic [KW-1:0]          rank;
   logic [CNT_W-1:0]       zero_total;
   logic [SAMP_W-1:0]      sat_sample;
   logic                   take;

   assign req_stall         = (state_ff != ST_IDLE);
   assign csr_ready         = 1'b1;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_accepted      = rsp_acc_ff;
   assign rsp_percentile_ms = rsp_ms_ff;
   assign rsp_worst_us      = rsp_worst_ff;

   always_comb begin
      state_in     = state_ff;
      limit_in     = limit_ff;
      pct_in       = pct_ff;
      wr_idx_in    = wr_idx_ff;
      held_in      = held_ff;
      worst_in     = worst_ff;
      rsp_valid_in = rsp_valid_ff;
      ring_in      = ring_ff;
      acc_in       = acc_ff;
      rank_prod_in = rank_prod_ff;
      k_rem_in     = k_rem_ff;
      alive_in     = alive_ff;
      grp_cnt_in   = grp_cnt_ff;
      bit_in       = bit_ff;
      sel_in       = sel_ff;
      conv_in      = conv_ff;
      rsp_acc_in   = rsp_acc_ff;
      rsp_ms_in    = rsp_ms_ff;
      rsp_worst_in = rsp_worst_ff;

      take       = 1'b0;
      sat_sample = (|req_duration_us[DUR_W-1:SAMP_W]) ? SAMP_MAX
                                                      : req_duration_us[SAMP_W-1:0];
      div_prod   = DIVP_W'(rank_prod_ff) * DIVP_W'(DIV100_MUL);
      rank       = div_prod[DIV100_SHIFT +: KW];

      // live samples whose current MSB is zero
      for (int i = 0; i < WINDOW; i++) begin
         zero_bits[i] = alive_ff[i] & ~ring_ff[i][SAMP_W-1];
      end

      zero_total = '0;
      for (int g = 0; g < NGRP; g++) begin
         zero_total = zero_total + CNT_W'(grp_cnt_ff[g]);
      end

      if (csr_valid) begin
         case (csr_index)
            REG_REJECT_LIMIT: limit_in = csr_data[LIMIT_W-1:0];
            REG_PERCENTILE:   pct_in   = csr_data[PCT_W-1:0];
            default: ;
         endcase
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               take     = req_duration_us <= DUR_W'(limit_ff);
               acc_in   = take;
               state_in = ST_RANK_MUL;
               if (take) begin
                  // accepted values fit in the limit width
                  if (req_duration_us[LIMIT_W-1:0] > worst_ff) begin
                     worst_in = req_duration_us[LIMIT_W-1:0];
                  end
                  ring_in[wr_idx_ff] = sat_sample;
                  wr_idx_in = (wr_idx_ff == IDX_W'(WINDOW - 1)) ? '0
                                                               : wr_idx_ff + 1'b1;
                  if (held_ff < CNT_W'(WINDOW)) begin
                     held_in = held_ff + 1'b1;
                  end
               end
            end
         end
         ST_RANK_MUL: begin
            rank_prod_in = PROD_W'(held_ff) * PROD_W'(pct_ff);
            state_in     = ST_RANK_DIV;
         end
         ST_RANK_DIV: begin
            if (held_ff == '0) begin
               k_rem_in = '0;
            end else if (rank >= KW'(held_ff)) begin
               k_rem_in = KW'(held_ff) - 1'b1;
            end else begin
               k_rem_in = rank;
            end
            for (int i = 0; i < WINDOW; i++) begin
               alive_in[i] = (CNT_W'(i) < held_ff);
            end
            bit_in   = '0;
            state_in = ST_COUNT;
         end
         ST_COUNT: begin
            for (int g = 0; g < NGRP; g++) begin
               grp_cnt_in[g] = '0;
               for (int b = 0; b < GRP_SIZE; b++) begin
                  if (g * GRP_SIZE + b < WINDOW) begin
                     grp_cnt_in[g] = grp_cnt_in[g]
                                   + GRP_CNT_W'(zero_bits[g * GRP_SIZE + b]);
                  end
               end
            end
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (k_rem_ff < KW'(zero_total)) begin
               alive_in = zero_bits;
               sel_in   = {sel_ff[SAMP_W-2:0], 1'b0};
            end else begin
               alive_in = alive_ff & ~zero_bits;
               k_rem_in = k_rem_ff - KW'(zero_total);
               sel_in   = {sel_ff[SAMP_W-2:0], 1'b1};
            end
            // rotate every entry; after SAMP_W steps it is back in place
            for (int i = 0; i < WINDOW; i++) begin
               ring_in[i] = {ring_ff[i][SAMP_W-2:0], ring_ff[i][SAMP_W-1]};
            end
            bit_in   = bit_ff + 1'b1;
            state_in = (bit_ff == BIT_W'(SAMP_W - 1)) ? ST_CONV_MUL : ST_COUNT;
         end
         ST_CONV_MUL: begin
            conv_in  = CONV_W'({1'b0, sel_ff} + ROUND_HALF) * CONV_W'(DIV1000_MUL);
            state_in = ST_RESULT;
         end
         ST_RESULT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_acc_in   = acc_ff;
               rsp_ms_in    = (held_ff < CNT_W'(2)) ? '0
                                                    : conv_ff[DIV1000_SHIFT +: MS_W];
               rsp_worst_in = worst_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         limit_ff     <= LIMIT_RESET;
         pct_ff       <= PCT_RESET;
         wr_idx_ff    <= '0;
         held_ff      <= '0;
         worst_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         limit_ff     <= limit_in;
         pct_ff       <= pct_in;
         wr_idx_ff    <= wr_idx_in;
         held_ff      <= held_in;
         worst_ff     <= worst_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ring_ff      <= ring_in;
      acc_ff       <= acc_in;
      rank_prod_ff <= rank_prod_in;
      k_rem_ff     <= k_rem_in;
      alive_ff     <= alive_in;
      grp_cnt_ff   <= grp_cnt_in;
      bit_ff       <= bit_in;
      sel_ff       <= sel_in;
      conv_ff      <= conv_in;
      rsp_acc_ff   <= rsp_acc_in;
      rsp_ms_ff    <= rsp_ms_in;
      rsp_worst_ff <= rsp_worst_in;
   end

   // pointer and fill count stay inside the ring
   a_ring_bounds: assert property (@(posedge clock) disable iff (reset)
      (held_ff <= CNT_W'(WINDOW)) && (wr_idx_ff <= IDX_W'(WINDOW - 1)))
      else $error("ring pointer or fill count out of range");

   // the remaining rank always points inside the surviving candidates
   a_rank_alive: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_COUNT && held_ff != '0) |->
         (int'(k_rem_ff) < $countones(alive_ff)))
      else $error("selection rank lost its candidates");

   // under two held samples the percentile reads zero
   a_short_zero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RESULT && held_ff < CNT_W'(2) && !(rsp_valid_ff && rsp_stall))
         |=> (rsp_percentile_ms == '0))
      else $error("percentile not zero with fewer than two samples");

   // rounded milliseconds never pass the saturated sample range
   a_ms_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ms_ff <= MS_W'(MS_MAX)))
      else $error("percentile result out of range");

endmodule

[sim/percentile_checker.sv]
// Checker for the percentile tracker: predicts each result and compares it.
module percentile_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_stall,
   input  logic [swpt_pkg::DUR_W-1:0]      req_duration_us,
   input  logic                            rsp_valid,
   input  logic                            rsp_stall,
   input  logic                            rsp_accepted,
   input  logic [swpt_pkg::MS_W-1:0]       rsp_percentile_ms,
   input  logic [swpt_pkg::LIMIT_W-1:0]    rsp_worst_us,
   input  logic                            csr_valid,
   input  logic                            csr_ready,
   input  logic [swpt_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [swpt_pkg::CSR_DATA_W-1:0] csr_data,
   output int                              fail_count,
   output int                              outstanding
);
   import swpt_pkg::*;

   localparam int ROUND_US  = 500;
   localparam int US_PER_MS = 1000;
   localparam int PCT_SCALE = 100;
   localparam int MAX_LINES = 200;

   typedef struct packed {
      logic               accepted;
      logic [MS_W-1:0]    ms;
      logic [LIMIT_W-1:0] worst;
   } window_result_type;

   logic [SAMP_W-1:0]  ring [WINDOW];
   logic [IDX_W-1:0]   wr_ptr;
   logic [CNT_W-1:0]   held;
   logic [LIMIT_W-1:0] worst;
   logic [LIMIT_W-1:0] limit;
   logic [PCT_W-1:0]   pct;

   window_result_type expected_results[$];
   window_result_type want;
   int fails = 0;

   assign fail_count = fails;

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] exp_val);
      if (fails < MAX_LINES)
         $display("MISMATCH %s: got %0d, expected %0d", what, got, exp_val);
      fails++;
   endtask

   // store one sample (if within the limit) and rank the window
   function automatic window_result_type store_and_rank(input logic [DUR_W-1:0] dur);
      window_result_type r;
      logic [SAMP_W-1:0] sorted [WINDOW];
      logic [SAMP_W-1:0] v;
      int n;
      int i;
      int j;
      int k;
      int unsigned u;
      r.accepted = (dur <= limit);
      if (r.accepted) begin
         if (dur > worst)
            worst = dur[LIMIT_W-1:0];
         ring[wr_ptr] = (dur > SAMP_MAX) ? SAMP_MAX : dur[SAMP_W-1:0];
         wr_ptr = (wr_ptr == IDX_W'(WINDOW - 1)) ? '0 : wr_ptr + 1'b1;
         if (held < WINDOW)
            held = held + 1'b1;
      end
      r.worst = worst;
      r.ms = '0;
      n = int'(held);
      if (n >= 2) begin
         for (i = 0; i < n; i++)
            sorted[i] = ring[i];
         for (i = 1; i < n; i++) begin
            v = sorted[i];
            j = i;
            while (j > 0 && sorted[j-1] > v) begin
               sorted[j] = sorted[j-1];
               j--;
            end
            sorted[j] = v;
         end
         k = (n * int'(pct)) / PCT_SCALE;
         if (k >= n)
            k = n - 1;
         u = 32'(sorted[k]);
         r.ms = MS_W'((u + ROUND_US) / US_PER_MS);
      end
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WINDOW; i++)
            ring[i] = '0;
         wr_ptr = '0;
         held = '0;
         worst = '0;
         limit = LIMIT_RESET;
         pct = PCT_RESET;
         expected_results.delete();
      end else begin
         // results first: a result never belongs to a request taken at the same edge
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               report_mismatch("result with no transaction pending",
                               32'(rsp_percentile_ms), 32'd0);
            end else begin
               want = expected_results.pop_front();
               if (rsp_accepted !== want.accepted)
                  report_mismatch("accepted", 32'(rsp_accepted), 32'(want.accepted));
               if (rsp_percentile_ms !== want.ms)
                  report_mismatch("percentile_ms", 32'(rsp_percentile_ms), 32'(want.ms));
               if (rsp_worst_us !== want.worst)
                  report_mismatch("worst_us", 32'(rsp_worst_us), 32'(want.worst));
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_REJECT_LIMIT: limit = csr_data[LIMIT_W-1:0];
               REG_PERCENTILE:   pct = csr_data[PCT_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            expected_results.push_back(store_and_rank(req_duration_us));
      end
      outstanding <= expected_results.size();
   end

endmodule

[sim/tb.sv]
// Testbench top: drives samples and register writes, then reports the verdict.
module tb;
   import swpt_pkg::*;

   localparam int PHASES          = 10;
   localparam int ITEMS_PER_PHASE = 112;
   localparam int IDLE_LIMIT      = 4000;
   localparam int DRAIN_CYCLES    = 80;
   localparam int SMALL_CAP       = 70000;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_A = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_B = 2'd3;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic [DUR_W-1:0]      req_duration_us;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic                  rsp_accepted;
   logic [MS_W-1:0]       rsp_percentile_ms;
   logic [LIMIT_W-1:0]    rsp_worst_us;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   int error_count;
   int results_open;
   int gap_pct;
   int stall_pct;
   int samples_sent;
   int samples_stored;
   int reg_writes;
   int idle_cycles;
   logic [LIMIT_W-1:0] limit_now;

   sliding_window_percentile_tracker dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_duration_us   (req_duration_us),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_accepted      (rsp_accepted),
      .rsp_percentile_ms (rsp_percentile_ms),
      .rsp_worst_us      (rsp_worst_us),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   percentile_checker window_check (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_duration_us   (req_duration_us),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_accepted      (rsp_accepted),
      .rsp_percentile_ms (rsp_percentile_ms),
      .rsp_worst_us      (rsp_worst_us),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .fail_count        (error_count),
      .outstanding       (results_open)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
         $display("DONE: errors detected");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // result side back-pressure in bursts
   initial begin : stall_gen
      int burst;
      burst = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (burst > 0)
            burst--;
         else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct)
            burst = $urandom_range(1, 16);
         rsp_stall <= (burst > 0);
      end
   end

   task automatic send_duration(input logic [DUR_W-1:0] dur);
      int gap;
      req_valid <= 1'b1;
      req_duration_us <= dur;
      do @(posedge clock); while (req_stall);
      samples_sent++;
      if (dur <= limit_now)
         samples_stored++;
      gap = 0;
      if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct)
         gap = $urandom_range(1, 16);
      if (gap != 0) begin
         req_valid <= 1'b0;
         req_duration_us <= $urandom();
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (results_open != 0);
   endtask

   task automatic set_register(input logic [CSR_IDX_W-1:0] idx,
                               input logic [CSR_DATA_W-1:0] val);
      wait_for_results();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == REG_REJECT_LIMIT)
         limit_now = val[LIMIT_W-1:0];
      reg_writes++;
   endtask

   // mostly in-limit samples, plus boundary and wild values
   function automatic logic [DUR_W-1:0] pick_duration();
      int unsigned sel;
      int unsigned cap;
      sel = $urandom_range(0, 99);
      cap = (limit_now > SMALL_CAP) ? SMALL_CAP : limit_now;
      if (sel < 20)
         return $urandom_range(0, (cap > 3000) ? 3000 : cap);
      else if (sel < 55)
         return $urandom_range(0, cap);
      else if (sel < 70)
         return $urandom_range(0, limit_now);
      else if (sel < 78)
         return DUR_W'(limit_now);
      else if (sel < 86)
         return DUR_W'(limit_now) + 32'd1;
      else
         return $urandom();
   endfunction

   initial begin : stimulus
      int phase;
      int sent;
      logic [DUR_W-1:0] dur;
      logic [LIMIT_W-1:0] lim;
      logic [PCT_W-1:0] pc;

      reset <= 1'b1;
      req_valid <= 1'b0;
      req_duration_us <= '0;
      csr_valid <= 1'b0;
      csr_index <= REG_REJECT_LIMIT;
      csr_data <= '0;
      gap_pct = 20;
      stall_pct = 20;
      samples_sent = 0;
      samples_stored = 0;
      reg_writes = 0;
      limit_now = LIMIT_RESET;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed, starting from the reset settings
      send_duration(32'd0);          // one sample held: no rank
      send_duration(32'd0);          // selected sample is zero
      send_duration(32'd6000000);    // exactly at the limit
      send_duration(32'd6000001);    // just over: rejected
      send_duration(32'hFFFFFFFF);
      send_duration(32'd65535);
      send_duration(32'd65536);      // saturates in the ring
      send_duration(32'd499);
      send_duration(32'd500);
      send_duration(32'd1499);
      send_duration(32'd1500);
      set_register(REG_PERCENTILE, '0);   // smallest held sample
      send_duration(32'd2500);
      send_duration(32'd70000);
      // upper data bits must be dropped; rank clamps to the last entry
      set_register(REG_PERCENTILE, {{(CSR_DATA_W-PCT_W){1'b1}}, 7'd127});
      send_duration(32'd12345);
      send_duration(32'd1);
      set_register(REG_REJECT_LIMIT, '0);
      send_duration(32'd0);
      send_duration(32'd1);
      set_register(REG_REJECT_LIMIT, '1);
      send_duration(32'h00FFFFFF);
      send_duration(32'h01000000);
      set_register(REG_SPARE_A, '1);      // ignored
      set_register(REG_SPARE_B, '0);      // ignored
      send_duration(32'd40000);
      send_duration(32'd5);

      for (phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: begin lim = '1;            pc = 7'd1;   end
            1: begin lim = '0;            pc = 7'd99;  end
            2: begin lim = 24'd65535;     pc = 7'd100; end
            3: begin lim = LIMIT_W'($urandom()); pc = 7'd0; end
            4: begin lim = LIMIT_RESET;   pc = 7'd50;  end
            5: begin lim = LIMIT_W'($urandom_range(1000, SMALL_CAP)); pc = 7'd127; end
            default: begin
               lim = ($urandom_range(0, 3) == 0) ? LIMIT_W'($urandom())
                                                 : LIMIT_W'($urandom_range(0, 200000));
               pc = PCT_W'($urandom_range(1, 99));
            end
         endcase
         if (phase == PHASES - 1) begin
            gap_pct = 0;
            stall_pct = 0;
         end else if (phase % 3 == 1) begin
            gap_pct = 0;
            stall_pct = 0;
         end else begin
            gap_pct = $urandom_range(5, 40);
            stall_pct = $urandom_range(5, 40);
         end
         set_register(REG_REJECT_LIMIT, lim);
         set_register(REG_PERCENTILE, CSR_DATA_W'({$urandom(), pc}));
         sent = 0;
         while (sent < ITEMS_PER_PHASE) begin
            dur = pick_duration();
            send_duration(dur);
            sent++;
         end
      end

      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("covered %0d samples (%0d within the limit) over %0d register writes",
               samples_sent, samples_stored, reg_writes);
      $display("limits from 0 to full scale, percentiles 0 to 127, spare indexes ignored");
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
